// File: hdl/rbf_pkg.sv
`timescale 1ns / 1ps

package rbf_pkg;

    // Data and coefficient formats
    localparam int SAMPLE_W  = 32;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 4;

    // Configuration register map
    localparam int NUM_REGS  = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_HP_GAIN = 3'd0;
    localparam logic [2:0] REG_HP_FB1  = 3'd1;
    localparam logic [2:0] REG_HP_FB2  = 3'd2;
    localparam logic [2:0] REG_SS_GAIN = 3'd3;
    localparam logic [2:0] REG_SS_FB1  = 3'd4;
    localparam logic [2:0] REG_SS_FB2  = 3'd5;

    localparam logic [COEF_W-1:0] HP_GAIN_RST = 32'h4000_0000;
    localparam logic [COEF_W-1:0] SS_GAIN_RST = 32'h4000_0000;

    // Saturation bounds, sign-extended to the accumulator width
    localparam logic [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

    // Multiplier operand pairs
    localparam logic [3:0] TERM_G_X     = 4'd0;
    localparam logic [3:0] TERM_G_X1    = 4'd1;
    localparam logic [3:0] TERM_G_X2    = 4'd2;
    localparam logic [3:0] TERM_F1_HP1  = 4'd3;
    localparam logic [3:0] TERM_F2_HP2  = 4'd4;
    localparam logic [3:0] TERM_C1_HP   = 4'd5;
    localparam logic [3:0] TERM_C1_HP1  = 4'd6;
    localparam logic [3:0] TERM_C2_R1   = 4'd7;
    localparam logic [3:0] TERM_C3_R2   = 4'd8;

    // Accumulator operations on the registered product
    localparam logic [2:0] ACC_LOAD = 3'd0;
    localparam logic [2:0] ACC_ADD  = 3'd1;
    localparam logic [2:0] ACC_SUB  = 3'd2;
    localparam logic [2:0] ACC_ADD2 = 3'd3;
    localparam logic [2:0] ACC_SUB2 = 3'd4;

    typedef struct packed {
        logic [COEF_W-1:0] hp_gain;
        logic [COEF_W-1:0] hp_fb1;
        logic [COEF_W-1:0] hp_fb2;
        logic [COEF_W-1:0] ss_gain;
        logic [COEF_W-1:0] ss_fb1;
        logic [COEF_W-1:0] ss_fb2;
    } coefs_t;

    typedef struct packed {
        logic       capture;
        logic       clear_hist;
        logic       mul_en;
        logic [3:0] term_sel;
        logic       acc_en;
        logic [2:0] acc_op;
        logic       hp_latch;
        logic       out_load;
        logic       zero_out;
    } cmd_t;

endpackage

// File: hdl/rbf_cfg.sv
`timescale 1ns / 1ps

module rbf_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rbf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output rbf_pkg::coefs_t                   coefs
);

    logic [rbf_pkg::COEF_W-1:0] hp_gain_reg;
    logic [rbf_pkg::COEF_W-1:0] hp_fb1_reg;
    logic [rbf_pkg::COEF_W-1:0] hp_fb2_reg;
    logic [rbf_pkg::COEF_W-1:0] ss_gain_reg;
    logic [rbf_pkg::COEF_W-1:0] ss_fb1_reg;
    logic [rbf_pkg::COEF_W-1:0] ss_fb2_reg;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Register file; writes beyond the map are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_gain_reg <= rbf_pkg::HP_GAIN_RST;
            hp_fb1_reg  <= '0;
            hp_fb2_reg  <= '0;
            ss_gain_reg <= rbf_pkg::SS_GAIN_RST;
            ss_fb1_reg  <= '0;
            ss_fb2_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rbf_pkg::REG_HP_GAIN: hp_gain_reg <= pwdata;
                rbf_pkg::REG_HP_FB1:  hp_fb1_reg  <= pwdata;
                rbf_pkg::REG_HP_FB2:  hp_fb2_reg  <= pwdata;
                rbf_pkg::REG_SS_GAIN: ss_gain_reg <= pwdata;
                rbf_pkg::REG_SS_FB1:  ss_fb1_reg  <= pwdata;
                rbf_pkg::REG_SS_FB2:  ss_fb2_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            rbf_pkg::REG_HP_GAIN: prdata = hp_gain_reg;
            rbf_pkg::REG_HP_FB1:  prdata = hp_fb1_reg;
            rbf_pkg::REG_HP_FB2:  prdata = hp_fb2_reg;
            rbf_pkg::REG_SS_GAIN: prdata = ss_gain_reg;
            rbf_pkg::REG_SS_FB1:  prdata = ss_fb1_reg;
            rbf_pkg::REG_SS_FB2:  prdata = ss_fb2_reg;
            default:              prdata = '0;
        endcase
    end

    assign coefs.hp_gain = hp_gain_reg;
    assign coefs.hp_fb1  = hp_fb1_reg;
    assign coefs.hp_fb2  = hp_fb2_reg;
    assign coefs.ss_gain = ss_gain_reg;
    assign coefs.ss_fb1  = ss_fb1_reg;
    assign coefs.ss_fb2  = ss_fb2_reg;

endmodule

// File: hdl/rbf_ctrl.sv
`timescale 1ns / 1ps

module rbf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rbf_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Sequencer steps: high-pass sum, high-pass round, roof sum
    localparam logic [3:0] STEP_MUL_X    = 4'd0;
    localparam logic [3:0] STEP_MUL_X1   = 4'd1;
    localparam logic [3:0] STEP_MUL_X2   = 4'd2;
    localparam logic [3:0] STEP_MUL_HP1  = 4'd3;
    localparam logic [3:0] STEP_MUL_HP2  = 4'd4;
    localparam logic [3:0] STEP_HP_LAST  = 4'd5;
    localparam logic [3:0] STEP_HP_RND   = 4'd6;
    localparam logic [3:0] STEP_MUL_HP   = 4'd7;
    localparam logic [3:0] STEP_MUL_HPP  = 4'd8;
    localparam logic [3:0] STEP_MUL_R1   = 4'd9;
    localparam logic [3:0] STEP_MUL_R2   = 4'd10;
    localparam logic [3:0] STEP_RF_LAST  = 4'd11;

    localparam logic [1:0] WARM_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] warm_reg, warm_next;
    logic       zero_reg, zero_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] warm_eff;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        warm_next  = warm_reg;
        zero_next  = zero_reg;
        warm_eff   = s_tuser ? 2'd0 : warm_reg;

        cmd            = '0;
        cmd.zero_out   = zero_reg;
        cmd.term_sel   = rbf_pkg::TERM_G_X;
        cmd.acc_op     = rbf_pkg::ACC_LOAD;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.clear_hist = s_tuser;
                    cnt_next       = STEP_MUL_X;
                    if (warm_eff < WARM_DONE)
                    begin
                        // Warm-up item: no arithmetic, outputs are zero.
                        warm_next  = warm_eff + 2'd1;
                        zero_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        warm_next  = warm_eff;
                        zero_next  = 1'b0;
                        state_next = S_RUN;
                    end
                end
            end

            S_RUN:
            begin
                cnt_next = cnt_reg + 4'd1;
                case (cnt_reg)
                    STEP_MUL_X:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_G_X;
                    end
                    STEP_MUL_X1:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_G_X1;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_LOAD;
                    end
                    STEP_MUL_X2:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_G_X2;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_SUB2;
                    end
                    STEP_MUL_HP1:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_F1_HP1;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_ADD;
                    end
                    STEP_MUL_HP2:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_F2_HP2;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_ADD;
                    end
                    STEP_HP_LAST:
                    begin
                        cmd.acc_en = 1'b1;
                        cmd.acc_op = rbf_pkg::ACC_SUB;
                    end
                    STEP_HP_RND:
                    begin
                        cmd.hp_latch = 1'b1;
                    end
                    STEP_MUL_HP:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_C1_HP;
                    end
                    STEP_MUL_HPP:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_C1_HP1;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_LOAD;
                    end
                    STEP_MUL_R1:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_C2_R1;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_ADD;
                    end
                    STEP_MUL_R2:
                    begin
                        cmd.mul_en   = 1'b1;
                        cmd.term_sel = rbf_pkg::TERM_C3_R2;
                        cmd.acc_en   = 1'b1;
                        cmd.acc_op   = rbf_pkg::ACC_ADD2;
                    end
                    STEP_RF_LAST:
                    begin
                        cmd.acc_en = 1'b1;
                        cmd.acc_op = rbf_pkg::ACC_ADD2;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            warm_reg      <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            warm_reg      <= warm_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/rbf_dp.sv
`timescale 1ns / 1ps

module rbf_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rbf_pkg::cmd_t                     cmd,
    input  rbf_pkg::coefs_t                   coefs,
    input  logic [rbf_pkg::SAMPLE_W-1:0]      sample,
    output logic [rbf_pkg::SAMPLE_W-1:0]      roof_value,
    output logic [rbf_pkg::SAMPLE_W-1:0]      highpass_value
);

    localparam int SW = rbf_pkg::SAMPLE_W;
    localparam int AW = rbf_pkg::ACC_W;
    localparam int PW = rbf_pkg::PROD_W;

    // Round half up by shift bits, then clamp to the sample range.
    function automatic logic [SW-1:0] rnd_sat(input logic [AW-1:0] acc, input int shift);
        logic signed [AW-1:0] sum;
        logic signed [AW-1:0] shifted;
        logic [SW-1:0]        res;
        sum     = $signed(acc) + $signed(AW'(1) << (shift - 1));
        shifted = sum >>> shift;
        if (shifted > $signed(rbf_pkg::SAT_MAX))
            res = rbf_pkg::SAT_MAX[SW-1:0];
        else if (shifted < $signed(rbf_pkg::SAT_MIN))
            res = rbf_pkg::SAT_MIN[SW-1:0];
        else
            res = shifted[SW-1:0];
        return res;
    endfunction

    logic [SW-1:0]              x_reg;
    logic [SW-1:0]              x1_reg, x2_reg;
    logic [SW-1:0]              hp1_reg, hp2_reg;
    logic [SW-1:0]              r1_reg, r2_reg;
    logic [SW-1:0]              hp_reg;
    logic [PW-1:0]              prod_reg;
    logic [AW-1:0]              acc_reg, acc_next;
    logic [SW-1:0]              roof_out_reg, hp_out_reg;
    logic [rbf_pkg::COEF_W-1:0] mul_a;
    logic [SW-1:0]              mul_b;
    logic [AW-1:0]              prod_ext;
    logic [SW-1:0]              hp_val, roof_val;

    // Operand select for the shared multiplier
    always_comb
    begin
        case (cmd.term_sel)
            rbf_pkg::TERM_G_X:    begin mul_a = coefs.hp_gain; mul_b = x_reg;   end
            rbf_pkg::TERM_G_X1:   begin mul_a = coefs.hp_gain; mul_b = x1_reg;  end
            rbf_pkg::TERM_G_X2:   begin mul_a = coefs.hp_gain; mul_b = x2_reg;  end
            rbf_pkg::TERM_F1_HP1: begin mul_a = coefs.hp_fb1;  mul_b = hp1_reg; end
            rbf_pkg::TERM_F2_HP2: begin mul_a = coefs.hp_fb2;  mul_b = hp2_reg; end
            rbf_pkg::TERM_C1_HP:  begin mul_a = coefs.ss_gain; mul_b = hp_reg;  end
            rbf_pkg::TERM_C1_HP1: begin mul_a = coefs.ss_gain; mul_b = hp1_reg; end
            rbf_pkg::TERM_C2_R1:  begin mul_a = coefs.ss_fb1;  mul_b = r1_reg;  end
            rbf_pkg::TERM_C3_R2:  begin mul_a = coefs.ss_fb2;  mul_b = r2_reg;  end
            default:              begin mul_a = '0;            mul_b = '0;      end
        endcase
    end

    // Accumulator update from the registered product
    assign prod_ext = {{(AW - PW){prod_reg[PW-1]}}, prod_reg};

    always_comb
    begin
        case (cmd.acc_op)
            rbf_pkg::ACC_LOAD: acc_next = prod_ext;
            rbf_pkg::ACC_ADD:  acc_next = acc_reg + prod_ext;
            rbf_pkg::ACC_SUB:  acc_next = acc_reg - prod_ext;
            rbf_pkg::ACC_ADD2: acc_next = acc_reg + {prod_ext[AW-2:0], 1'b0};
            rbf_pkg::ACC_SUB2: acc_next = acc_reg - {prod_ext[AW-2:0], 1'b0};
            default:           acc_next = acc_reg;
        endcase
    end

    // Final stage values; warm-up items give zero.
    assign hp_val   = cmd.zero_out ? '0 : hp_reg;
    assign roof_val = cmd.zero_out ? '0 : rnd_sat(acc_reg, rbf_pkg::COEF_FRAC + 1);

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            x_reg <= sample;
        if (cmd.mul_en)
            prod_reg <= PW'($signed(mul_a) * $signed(mul_b));
        if (cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.hp_latch)
            hp_reg <= rnd_sat(acc_reg, rbf_pkg::COEF_FRAC);
        if (cmd.out_load)
        begin
            roof_out_reg <= roof_val;
            hp_out_reg   <= hp_val;
        end
    end

    // Filter history; cleared at reset and at the start of a series.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            hp1_reg <= '0;
            hp2_reg <= '0;
            r1_reg  <= '0;
            r2_reg  <= '0;
        end
        else if (cmd.capture && cmd.clear_hist)
        begin
            x1_reg  <= '0;
            x2_reg  <= '0;
            hp1_reg <= '0;
            hp2_reg <= '0;
            r1_reg  <= '0;
            r2_reg  <= '0;
        end
        else if (cmd.out_load)
        begin
            x2_reg  <= x1_reg;
            x1_reg  <= x_reg;
            hp2_reg <= hp1_reg;
            hp1_reg <= hp_val;
            r2_reg  <= r1_reg;
            r1_reg  <= roof_val;
        end
    end

    assign roof_value     = roof_out_reg;
    assign highpass_value = hp_out_reg;

endmodule

// File: hdl/roofing_bandlimit_filter.sv
`timescale 1ns / 1ps

// Roofing band-limit filter: a two-pole high-pass stage followed by a two-pole
// super smoother, on signed Q16.16 samples with six Q2.30 coefficients set over
// the APB port. Each input transaction yields one output transaction carrying
// both stage outputs, rounded half up and saturated to 32 bits. A set tuser bit
// starts a new series; the first two samples of a series (and the first two after
// reset) give zero outputs. A normal item passes one accept step, twelve steps of
// the single shared 32x32 multiplier and its accumulator, and one final step into
// the output register; a warm-up item skips the arithmetic steps.
// The next item is accepted as soon as the previous one has moved into the
// output register, even while that result still waits for tready.
module roofing_bandlimit_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rbf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rbf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rbf_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
    input  logic                               s_tuser,   // [0] series_start
    // Output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*rbf_pkg::SAMPLE_W-1:0]     m_tdata    // [31:0] roof_value, [63:32] highpass_value
);

    rbf_pkg::coefs_t               coefs;
    rbf_pkg::cmd_t                 cmd;
    logic [rbf_pkg::SAMPLE_W-1:0]  roof_value;
    logic [rbf_pkg::SAMPLE_W-1:0]  highpass_value;

    // Coefficient registers
    rbf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // Sequencer and handshakes
    rbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Multiply-accumulate datapath and history
    rbf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .coefs          (coefs),
        .sample         (s_tdata),
        .roof_value     (roof_value),
        .highpass_value (highpass_value)
    );

    assign m_tdata = {highpass_value, roof_value};

endmodule
